FILE: design/lz77_pkg.sv
package lz77_pkg;

  localparam int unsigned WINDOW_SIZE    = 4096;
  localparam int unsigned LOOKAHEAD_SIZE = 18;
  localparam int unsigned HIST_DEPTH     = 8192;
  localparam int unsigned HIST_AW        = $clog2(HIST_DEPTH);
  localparam int unsigned NUM_CELLS      = LOOKAHEAD_SIZE + 1;
  localparam int unsigned CELL_IW        = $clog2(NUM_CELLS);
  localparam int unsigned DIST_W         = 13;
  localparam int unsigned LEN_W          = 5;
  localparam int unsigned SCAN_W         = HIST_AW + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_EMIT
  } state_e;

  // control broadcast to every cell of the match row
  typedef struct packed {
    logic       clear;
    logic       step;
    logic [7:0] hist_byte;
  } cell_ctrl_t;

endpackage

FILE: design/lz77_cell.sv
module lz77_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lz77_pkg::cell_ctrl_t ctrl_i,
  input  logic                load_i,
  input  logic [7:0]          load_byte_i,
  input  logic                prev_i,
  output logic                hit_o,
  output logic                match_o,
  output logic [7:0]          byte_o
);

  logic [7:0] byte_q;
  logic       match_q, match_d;

  // candidate that matched this cell's position so far extends by one byte
  assign hit_o = prev_i & (ctrl_i.hist_byte == byte_q);

  always_comb begin
    match_d = match_q;
    if (ctrl_i.clear) begin
      match_d = 1'b0;
    end else if (ctrl_i.step) begin
      match_d = hit_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      byte_q <= load_byte_i;
    end
  end

  assign match_o = match_q;
  assign byte_o  = byte_q;

endmodule

FILE: design/lz77_greedy_compressor_top.sv
// Greedy LZ77 compressor, one raw byte per input item, one token per output item.
// Input channel s_axis_*: tdata carries the byte, tlast marks the final byte of a stream.
// Output channel m_axis_*: tdata = {next_byte, match_length, back_distance},
// tuser flags a padding next byte, tlast marks the final token of a stream.
// Bytes are buffered until 19 are pending (or tlast arrives); then a token is built:
// the pending bytes are read into a row of 19 cells (one memory read per cycle),
// then every byte of the window is streamed past the row, one per cycle, and each
// cell extends the candidate match it holds. Both the load and the scan go through
// the single read port of the history memory.
// Input is taken only while no token is being built; a stalled receiver holds the
// finished token in the output register and the next token waits behind it.
// On tlast all pending tokens are flushed and the window is emptied.
// Reset clears pointers and counts; the history memory needs no clearing pass.
module lz77_greedy_compressor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,   // end_of_data
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // back_distance[12:0], match_length[17:13], next_byte[25:18]
  output logic [0:0]  m_axis_tuser,   // next_is_padding
  output logic        m_axis_tlast    // final_token
);

  localparam int unsigned AW = lz77_pkg::HIST_AW;
  localparam int unsigned SW = lz77_pkg::SCAN_W;
  localparam int unsigned LW = lz77_pkg::LEN_W;
  localparam int unsigned DW = lz77_pkg::DIST_W;
  localparam int unsigned NC = lz77_pkg::NUM_CELLS;
  localparam int unsigned LA = lz77_pkg::LOOKAHEAD_SIZE;

  lz77_pkg::state_e state_q, state_d;

  logic [7:0]    hist_mem [lz77_pkg::HIST_DEPTH];
  logic [7:0]    rdata_q;
  logic [AW-1:0] wp_q, wp_d;
  logic [LW-1:0] pend_q, pend_d;
  logic [DW-1:0] wf_q, wf_d;
  logic          last_q, last_d;
  logic [SW-1:0] iss_q, iss_d;
  logic          rd_v_q;
  logic [SW-1:0] rd_idx_q;
  logic [LW-1:0] best_len_q, best_len_d;
  logic [DW-1:0] best_dist_q, best_dist_d;
  logic          m_valid_q, m_valid_d;
  logic [DW-1:0] o_dist_q;
  logic [LW-1:0] o_len_q;
  logic [7:0]    o_byte_q;
  logic          o_pad_q, o_fin_q;

  logic          in_acc, rd_en, load_done, scan_done, emit, out_free;
  logic [AW-1:0] rd_addr, cur;
  logic [LW-1:0] maxlen;
  logic [SW-1:0] nscan;
  lz77_pkg::cell_ctrl_t cctrl;
  logic [NC-1:0] hit, match;
  logic [7:0]    cbyte [NC];

  logic          pad;
  logic [LW-1:0] consumed;
  logic [7:0]    nbyte;
  logic [SW-1:0] wf_sum;

  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign out_free = ~m_valid_q | m_axis_tready;
  assign cur      = wp_q - AW'(pend_q);
  assign maxlen   = (pend_q < LW'(LA)) ? pend_q : LW'(LA);
  assign nscan    = (wf_q == '0) ? '0 : ({1'b0, wf_q} + SW'(maxlen) - SW'(1));
  assign load_done = (iss_q == SW'(pend_q)) & ~rd_v_q;
  assign scan_done = (iss_q == nscan) & ~rd_v_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lz77_pkg::ST_IDLE: begin
        if (in_acc && (s_axis_tlast || pend_q == LW'(LA))) begin
          state_d = lz77_pkg::ST_LOAD;
        end
      end
      lz77_pkg::ST_LOAD: begin
        if (load_done) begin
          state_d = lz77_pkg::ST_SCAN;
        end
      end
      lz77_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = lz77_pkg::ST_EMIT;
        end
      end
      lz77_pkg::ST_EMIT: begin
        if (out_free) begin
          if (last_q && pend_d != '0) begin
            state_d = lz77_pkg::ST_LOAD;
          end else begin
            state_d = lz77_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = lz77_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready   = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = cur + iss_q[AW-1:0];
    emit            = 1'b0;
    cctrl.clear     = 1'b0;
    cctrl.step      = 1'b0;
    cctrl.hist_byte = rdata_q;
    case (state_q)
      lz77_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      lz77_pkg::ST_LOAD: begin
        rd_en       = (iss_q != SW'(pend_q));
        cctrl.clear = load_done;
      end
      lz77_pkg::ST_SCAN: begin
        rd_en      = (iss_q != nscan);
        rd_addr    = cur - wf_q + iss_q[AW-1:0];
        cctrl.step = rd_v_q;
      end
      lz77_pkg::ST_EMIT: begin
        emit = out_free;
      end
      default: ;
    endcase
  end

  // history memory
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hist_mem[wp_q] <= s_axis_tdata;
    end
    if (rd_en) begin
      rdata_q <= hist_mem[rd_addr];
    end
  end

  // match row
  for (genvar i = 0; i < NC; i++) begin : g_cell
    logic prev;
    if (i == 0) begin : g_first
      assign prev = 1'b1;
    end else begin : g_next
      assign prev = match[i-1];
    end
    lz77_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cctrl),
      .load_i      (rd_v_q && state_q == lz77_pkg::ST_LOAD &&
                    rd_idx_q[lz77_pkg::CELL_IW-1:0] == lz77_pkg::CELL_IW'(i)),
      .load_byte_i (rdata_q),
      .prev_i      (prev),
      .hit_o       (hit[i]),
      .match_o     (match[i]),
      .byte_o      (cbyte[i])
    );
  end

  // best match tracking: longest candidate, first reached wins
  always_comb begin
    logic [LW-1:0] cand;
    cand        = '0;
    best_len_d  = best_len_q;
    best_dist_d = best_dist_q;
    if (cctrl.clear) begin
      best_len_d  = '0;
      best_dist_d = '0;
    end else if (cctrl.step) begin
      for (int k = 1; k <= int'(LA); k++) begin
        if (LW'(k) <= maxlen && hit[k-1] &&
            ({1'b0, wf_q} + SW'(k) >= rd_idx_q + SW'(2))) begin
          cand = LW'(k);
        end
      end
      if (cand > best_len_q) begin
        best_len_d  = cand;
        best_dist_d = DW'({1'b0, wf_q} + SW'(cand) - SW'(1) - rd_idx_q);
      end
    end
  end

  // token assembly
  assign pad      = (best_len_q >= pend_q);
  assign consumed = pad ? pend_q : (best_len_q + LW'(1));
  assign nbyte    = pad ? 8'd0 : cbyte[best_len_q];
  assign wf_sum   = {1'b0, wf_q} + SW'(consumed);

  always_comb begin
    wp_d      = wp_q;
    pend_d    = pend_q;
    wf_d      = wf_q;
    last_d    = last_q;
    iss_d     = iss_q;
    m_valid_d = m_valid_q;
    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (in_acc) begin
      wp_d   = wp_q + AW'(1);
      pend_d = pend_q + LW'(1);
      last_d = s_axis_tlast;
      iss_d  = '0;
    end
    if (rd_en) begin
      iss_d = iss_q + SW'(1);
    end
    if (cctrl.clear) begin
      iss_d = '0;
    end
    if (emit) begin
      m_valid_d = 1'b1;
      pend_d    = pend_q - consumed;
      iss_d     = '0;
      if (wf_sum > SW'(lz77_pkg::WINDOW_SIZE)) begin
        wf_d = DW'(lz77_pkg::WINDOW_SIZE);
      end else begin
        wf_d = wf_sum[DW-1:0];
      end
      if (last_q && consumed >= pend_q) begin
        wf_d   = '0;
        last_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lz77_pkg::ST_IDLE;
      wp_q        <= '0;
      pend_q      <= '0;
      wf_q        <= '0;
      last_q      <= 1'b0;
      iss_q       <= '0;
      rd_v_q      <= 1'b0;
      rd_idx_q    <= '0;
      best_len_q  <= '0;
      best_dist_q <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      pend_q      <= pend_d;
      wf_q        <= wf_d;
      last_q      <= last_d;
      iss_q       <= iss_d;
      rd_v_q      <= rd_en;
      rd_idx_q    <= iss_q;
      best_len_q  <= best_len_d;
      best_dist_q <= best_dist_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      o_dist_q <= best_dist_q;
      o_len_q  <= best_len_q;
      o_byte_q <= nbyte;
      o_pad_q  <= pad;
      o_fin_q  <= last_q && consumed >= pend_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, o_byte_q, o_len_q, o_dist_q};
  assign m_axis_tuser  = o_pad_q;
  assign m_axis_tlast  = o_fin_q;

endmodule

FILE: design/lz77_chk.sv
module lz77_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tlast))
    else $error("token changed while stalled");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[25:18] == 8'd0)
    else $error("padding token with nonzero next byte");

  a_len_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[17:13] == 5'd0) == (m_axis_tdata[12:0] == 13'd0)))
    else $error("length and distance disagree on literal");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[17:13] <= 5'(lz77_pkg::LOOKAHEAD_SIZE) &&
    m_axis_tdata[12:0] <= 13'(lz77_pkg::WINDOW_SIZE) && m_axis_tdata[31:26] == 6'd0)
    else $error("token field out of range");

endmodule

bind lz77_greedy_compressor_top lz77_chk u_lz77_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: verif/lz77_greedy_compressor_top_tb.sv
module lz77_greedy_compressor_top_tb;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       drain;
  } byte_item_t;

  typedef struct {
    logic [lz77_pkg::DIST_W-1:0] back_dist;
    logic [lz77_pkg::LEN_W-1:0]  len;
    logic [7:0]                  next;
    logic                        pad;
    logic                        fin;
  } token_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;

  lz77_greedy_compressor_top dut (.*);

  always #5 clk_i = ~clk_i;

  byte_item_t byte_q[$];
  token_t     token_q[$];
  int         errors = 0;
  int         tokens_seen = 0;
  int         streams = 0;
  int         pads_seen = 0;
  int         longest = 0;
  int         bytes_sent = 0;
  int         send_gap = 0;
  int         recv_gap = 0;

  // predictor state
  logic [7:0] hist [lz77_pkg::HIST_DEPTH];
  int         wr_ptr = 0;
  int         pend = 0;
  int         wfill = 0;

  function automatic int ring_idx(int base, int back, int fwd);
    return ((base - back + 2 * lz77_pkg::HIST_DEPTH) + fwd) % lz77_pkg::HIST_DEPTH;
  endfunction

  function automatic void build_token(bit is_last);
    token_t t;
    int cur, maxlen, best_len, best_dist, st, k, used;
    cur = ring_idx(wr_ptr, pend, 0);
    maxlen = (pend < lz77_pkg::LOOKAHEAD_SIZE) ? pend : lz77_pkg::LOOKAHEAD_SIZE;
    best_len = 0;
    best_dist = 0;
    for (int d = wfill; d >= 1; d--) begin
      st = ring_idx(cur, d, 0);
      k = 0;
      while (k < maxlen && hist[(st + k) % lz77_pkg::HIST_DEPTH] ==
             hist[(cur + k) % lz77_pkg::HIST_DEPTH])
        k++;
      if (k > best_len) begin
        best_len = k;
        best_dist = d;
      end
    end
    t.back_dist = lz77_pkg::DIST_W'(best_dist);
    t.len = lz77_pkg::LEN_W'(best_len);
    t.pad = (best_len >= pend);
    t.next = t.pad ? 8'd0 : hist[(cur + best_len) % lz77_pkg::HIST_DEPTH];
    used = t.pad ? pend : best_len + 1;
    t.fin = is_last && used >= pend;
    token_q = {token_q, t};
    pend -= used;
    wfill += used;
    if (wfill > lz77_pkg::WINDOW_SIZE) wfill = lz77_pkg::WINDOW_SIZE;
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic last);
    hist[wr_ptr] = b;
    wr_ptr = (wr_ptr + 1) % lz77_pkg::HIST_DEPTH;
    pend++;
    if (!last) begin
      if (pend >= lz77_pkg::LOOKAHEAD_SIZE + 1) build_token(1'b0);
    end else begin
      while (pend > 0) build_token(1'b1);
      wfill = 0;
    end
  endfunction

  function automatic void add_byte(logic [7:0] b, logic last, logic drain = 1'b0);
    byte_item_t it;
    it.data = b;
    it.last = last;
    it.drain = drain;
    byte_q = {byte_q, it};
    bytes_sent++;
    if (last) streams++;
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (byte_q.size() > 0 && !(byte_q[0].drain && token_q.size() > 0)) begin
          byte_item_t it;
          it = byte_q.pop_front();
          s_axis_tdata <= it.data;
          s_axis_tlast <= it.last;
          s_axis_tvalid <= 1'b1;
          if (byte_q.size() > 25 && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 3);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        tokens_seen++;
        if (token_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected token %h user %b last %b",
                                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end else begin
          token_t t;
          t = token_q.pop_front();
          if (t.pad) pads_seen++;
          if (t.len > longest) longest = t.len;
          if (m_axis_tdata[12:0] !== t.back_dist || m_axis_tdata[17:13] !== t.len ||
              m_axis_tdata[25:18] !== t.next || m_axis_tuser[0] !== t.pad ||
              m_axis_tlast !== t.fin) begin
            errors++;
            if (errors <= 10)
              $display("token %0d: exp dist %0d len %0d next %h pad %b fin %b, got %0d %0d %h %b %b",
                       tokens_seen, t.back_dist, t.len, t.next, t.pad, t.fin,
                       m_axis_tdata[12:0], m_axis_tdata[17:13], m_axis_tdata[25:18],
                       m_axis_tuser[0], m_axis_tlast);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (byte_q.size() > 25 && $urandom_range(0, 4) == 0) recv_gap = $urandom_range(1, 3);
      end
    end
  end

  initial begin
    int n, mode, alpha;
    logic [7:0] seg [$];
    // directed: single byte, extremes, long run with overlap, repeat with padding
    add_byte(8'h00, 1'b1);
    add_byte(8'hff, 1'b1);
    for (int i = 0; i < 22; i++) add_byte(8'h5a, i == 21);
    add_byte(8'h41, 1'b0);
    add_byte(8'h42, 1'b0);
    add_byte(8'h41, 1'b0);
    add_byte(8'h42, 1'b1, 1'b1);
    // random streams
    while (bytes_sent < 160) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 25);
      mode = $urandom_range(0, 3);
      alpha = $urandom_range(1, 4);
      seg.delete();
      for (int i = 0; i < n; i++) begin
        logic [7:0] b;
        case (mode)
          0: b = 8'($urandom_range(0, 255));
          1: b = 8'(8'h30 + $urandom_range(0, alpha - 1));
          2: b = (i >= 4 && $urandom_range(0, 3) != 0) ? seg[i - $urandom_range(1, 4)]
                                                      : 8'($urandom_range(0, 255));
          default: b = (i % alpha == 0) ? 8'($urandom_range(0, 255)) : 8'hc3;
        endcase
        seg = {seg, b};
        add_byte(b, i == n - 1, i == 0 && $urandom_range(0, 9) == 0);
      end
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (byte_q.size() == 0);
    @(posedge clk_i);
    wait (!s_axis_tvalid && token_q.size() == 0);
    repeat (4300) @(posedge clk_i);
    if (token_q.size() != 0) begin
      errors += token_q.size();
      $display("%0d tokens never arrived", token_q.size());
    end
    $display("%0d bytes in %0d streams, %0d tokens checked, %0d padded, longest match %0d",
             bytes_sent, streams, tokens_seen, pads_seen, longest);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("timeout");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
